// ===== hw/rtl/twr_pkg.sv =====
// Shared types, constants and saturation helper for the ranging pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package twr_pkg;

  localparam int STAMP_BITS_DEF = 32;
  localparam int Q_BITS         = 64;
  localparam logic [31:0] MM_RESET = 32'd307397;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDIV = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [31:0] POS_LIM = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIM = 32'h8000_0000;

  // per-transaction side information traveling with the data
  typedef struct packed {
    logic vld;
    logic neg;
    logic zdiv;
  } twr_tag_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } twr_clamp_t;

  // clamp a sign and magnitude to signed 32 bits
  function automatic twr_clamp_t twr_clamp(input logic neg, input logic [63:0] mag);
    twr_clamp_t c;
    c.sat = 1'b0;
    if (neg) begin
      if (mag > {32'd0, NEG_LIM}) begin
        c.sat = 1'b1;
        c.val = NEG_LIM;
      end else begin
        c.val = ~mag[31:0] + 32'd1;
      end
    end else begin
      if (mag > {32'd0, POS_LIM}) begin
        c.sat = 1'b1;
        c.val = POS_LIM;
      end else begin
        c.val = mag[31:0];
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/twr_front.sv =====
// Front end: wrap-safe intervals, cross products (double-sided mode only), signed difference magnitude.
// Three register stages; depends on twr_pkg.
`default_nettype none
module twr_front import twr_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire logic                      mode,
  input  wire logic [31:0]               poll_tx,
  input  wire logic [31:0]               poll_rx,
  input  wire logic [31:0]               resp_tx,
  input  wire logic [31:0]               resp_rx,
  input  wire logic [31:0]               final_tx,
  input  wire logic [31:0]               final_rx,
  output twr_tag_t                       tag_o,
  output logic [2*STAMP_BITS-1:0]        mag_o,
  output logic [STAMP_BITS:0]            den_o
);
  localparam int S  = STAMP_BITS;
  localparam int DW = S + 1;
  localparam int NW = 2 * S;

  logic [S-1:0]  t1, r1, t2, r2, t3, r3;
  logic [S-1:0]  ra1_r, db1_r, ra2_r, db2_r;
  logic [S-1:0]  ra1_nxt, db1_nxt, ra2_nxt, db2_nxt;
  logic [DW-1:0] den1_r, den1_nxt, den2_r, den3_r;
  logic          vld1_r, mode1_r, vld2_r, zdiv2_r, zdiv2_nxt;
  logic [NW-1:0] x2_r, y2_r, x2_nxt, y2_nxt;
  twr_tag_t      tag3_r, tag3_nxt;
  logic [NW-1:0] mag3_r, mag3_nxt;

  always_comb begin
    t1 = S'(poll_tx);
    r1 = S'(poll_rx);
    t2 = S'(resp_tx);
    r2 = S'(resp_rx);
    t3 = S'(final_tx);
    r3 = S'(final_rx);
    ra1_nxt = r2 - t1;
    db1_nxt = t2 - r1;
    ra2_nxt = r3 - r2;
    db2_nxt = t3 - t2;
    den1_nxt = mode ? (DW'(ra2_nxt) + DW'(db2_nxt)) : DW'(2);
  end

  always_comb begin
    if (mode1_r) begin
      x2_nxt = NW'(ra1_r) * NW'(db2_r);
      y2_nxt = NW'(ra2_r) * NW'(db1_r);
    end else begin
      x2_nxt = NW'(ra1_r);
      y2_nxt = NW'(db1_r);
    end
    zdiv2_nxt = (den1_r == '0);
  end

  always_comb begin
    tag3_nxt.vld  = vld2_r;
    tag3_nxt.zdiv = zdiv2_r;
    tag3_nxt.neg  = (x2_r < y2_r);
    mag3_nxt      = tag3_nxt.neg ? (y2_r - x2_r) : (x2_r - y2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      tag3_r <= '0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      tag3_r <= tag3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= mode;
      ra1_r   <= ra1_nxt;
      db1_r   <= db1_nxt;
      ra2_r   <= ra2_nxt;
      db2_r   <= db2_nxt;
      den1_r  <= den1_nxt;
      x2_r    <= x2_nxt;
      y2_r    <= y2_nxt;
      zdiv2_r <= zdiv2_nxt;
      den2_r  <= den1_r;
      mag3_r  <= mag3_nxt;
      den3_r  <= den2_r;
    end
  end

  assign tag_o = tag3_r;
  assign mag_o = mag3_r;
  assign den_o = den3_r;
endmodule
`default_nettype wire

// ===== hw/rtl/twr_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, 64-bit quotient
// plus overflow flag. Depends on twr_pkg.
`default_nettype none
module twr_div import twr_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  twr_tag_t                   tag_i,
  input  wire logic [2*STAMP_BITS-1:0] mag_i,
  input  wire logic [STAMP_BITS:0]   den_i,
  output twr_tag_t                   tag_o,
  output logic [Q_BITS-1:0]          q_o,
  output logic                       ovf_o
);
  localparam int DW = STAMP_BITS + 1;
  localparam int NW = 2 * STAMP_BITS;
  localparam int EW = NW + Q_BITS;

  logic [EW-1:0] ext;
  logic [NW-1:0] hi;
  logic          ovf0;

  twr_tag_t          tag_r  [Q_BITS+1];
  logic              ovf_r  [Q_BITS+1];
  logic [DW-1:0]     den_r  [Q_BITS+1];
  logic [DW-1:0]     rem_r  [Q_BITS+1];
  logic [Q_BITS-1:0] low_r  [Q_BITS+1];
  logic [Q_BITS-1:0] q_r    [Q_BITS+1];

  // quotient fits 64 bits exactly when the part from bit 64 upward is below den
  always_comb begin
    ext  = {{Q_BITS{1'b0}}, mag_i};
    hi   = ext[EW-1:Q_BITS];
    ovf0 = (hi >= NW'(den_i));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= ovf0;
      den_r[0] <= den_i;
      rem_r[0] <= ovf0 ? '0 : DW'(hi);
      low_r[0] <= ext[Q_BITS-1:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    always_comb begin
      trial = {rem_r[k], low_r[k][Q_BITS-1]};
      ge    = (trial >= {1'b0, den_r[k]});
      diff  = trial - {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k+1] <= '0;
      end else if (en) begin
        tag_r[k+1] <= tag_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[k+1] <= ovf_r[k];
        den_r[k+1] <= den_r[k];
        rem_r[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_r[k+1] <= {low_r[k][Q_BITS-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][Q_BITS-2:0], ge};
      end
    end
  end

  assign tag_o = tag_r[Q_BITS];
  assign q_o   = q_r[Q_BITS];
  assign ovf_o = ovf_r[Q_BITS];
endmodule
`default_nettype wire

// ===== hw/rtl/twr_scale.sv =====
// Back end: tick saturation, millimetre scaling by two 32x32 partial products,
// and the output register. Depends on twr_pkg.
`default_nettype none
module twr_scale import twr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  twr_tag_t               tag_i,
  input  wire logic [Q_BITS-1:0] q_i,
  input  wire logic              ovf_i,
  input  wire logic [31:0]       mm,
  output logic                   vld_o,
  output logic [31:0]            ticks_o,
  output logic [31:0]            dist_o,
  output logic [1:0]             status_o
);
  twr_tag_t    taga_r, taga_nxt;
  logic        ovfa_r, mmz_r, tsat_r;
  logic [31:0] ticks_r;
  logic [63:0] pl_r, ph_r;
  twr_clamp_t  tc;

  logic        vld_r;
  logic [31:0] ticksb_r, dist_r, dist_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [95:0] prod;
  logic [63:0] dm;
  twr_clamp_t  dc;
  logic        dsat;

  always_comb begin
    taga_nxt     = tag_i;
    taga_nxt.neg = tag_i.neg && (q_i != '0);
    tc           = twr_clamp(taga_nxt.neg, q_i);
    if (ovf_i) begin
      tc.sat = 1'b1;
      tc.val = taga_nxt.neg ? NEG_LIM : POS_LIM;
    end
  end

  always_comb begin
    prod = {32'd0, pl_r} + {ph_r, 32'd0};
    dm   = prod[79:16];
    dc   = twr_clamp(taga_r.neg && (dm != '0), dm);
    dist_nxt = dc.val;
    dsat     = dc.sat;
    if (mmz_r) begin
      dist_nxt = '0;
      dsat     = 1'b0;
    end else if (ovfa_r || (prod[95:80] != '0)) begin
      dist_nxt = taga_r.neg ? NEG_LIM : POS_LIM;
      dsat     = 1'b1;
    end
    status_nxt = (tsat_r || dsat) ? ST_SAT : ST_OK;
    if (taga_r.zdiv) begin
      dist_nxt   = '0;
      status_nxt = ST_ZDIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taga_r <= '0;
      vld_r  <= 1'b0;
    end else if (en) begin
      taga_r <= taga_nxt;
      vld_r  <= taga_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovfa_r   <= ovf_i;
      mmz_r    <= (mm == '0);
      tsat_r   <= tc.sat;
      ticks_r  <= tc.val;
      pl_r     <= q_i[31:0] * mm;
      ph_r     <= q_i[63:32] * mm;
      ticksb_r <= taga_r.zdiv ? '0 : ticks_r;
      dist_r   <= dist_nxt;
      status_r <= status_nxt;
    end
  end

  assign vld_o    = vld_r;
  assign ticks_o  = ticksb_r;
  assign dist_o   = dist_r;
  assign status_o = status_r;
endmodule
`default_nettype wire

// ===== hw/rtl/twr_time_of_flight.sv =====
// Two-way ranging time of flight, single-sided and asymmetric double-sided.
// Pipeline: 3 front-end stages, 65 divider stages, 2 scaling stages.
// Throughput one transaction per cycle; the whole pipeline holds while the
// output register is full and out_tready is low.
// Reset (rst_n, synchronous) clears all valid bits and loads mm_per_tick_q16
// with 307397. Depends on twr_pkg, twr_front, twr_div, twr_scale.
`default_nettype none
module twr_time_of_flight import twr_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_data,      // mm_per_tick_q16
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // poll_tx, poll_rx, resp_tx, resp_rx, final_tx, final_rx (32 bits each)
  input  wire logic [191:0] in_tdata,
  input  wire logic         in_tuser,      // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,     // flight_ticks, distance_mm
  output logic [1:0]        out_tuser      // status
);
  logic [31:0] mm_r;
  logic        en;
  twr_tag_t    ftag, dtag;
  logic [2*STAMP_BITS-1:0] mag;
  logic [STAMP_BITS:0]     den;
  logic [Q_BITS-1:0]       q;
  logic                    ovf;
  logic [31:0]             ticks, dist_mm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_r <= MM_RESET;
    end else if (cfg_valid) begin
      mm_r <= cfg_data;
    end
  end

  // advance whenever the output register is empty or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  twr_front #(.STAMP_BITS(STAMP_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .mode     (in_tuser),
    .poll_tx  (in_tdata[31:0]),
    .poll_rx  (in_tdata[63:32]),
    .resp_tx  (in_tdata[95:64]),
    .resp_rx  (in_tdata[127:96]),
    .final_tx (in_tdata[159:128]),
    .final_rx (in_tdata[191:160]),
    .tag_o    (ftag),
    .mag_o    (mag),
    .den_o    (den)
  );

  twr_div #(.STAMP_BITS(STAMP_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (ftag),
    .mag_i (mag),
    .den_i (den),
    .tag_o (dtag),
    .q_o   (q),
    .ovf_o (ovf)
  );

  twr_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .tag_i    (dtag),
    .q_i      (q),
    .ovf_i    (ovf),
    .mm       (mm_r),
    .vld_o    (out_tvalid),
    .ticks_o  (ticks),
    .dist_o   (dist_mm),
    .status_o (out_tuser)
  );

  assign out_tdata = {dist_mm, ticks};
endmodule
`default_nettype wire
